// ===== hdl/npta_pkg.sv =====
// ----------------------------------------------------------------------------
// npta_pkg: shared types and constants of the node presence table
// Holds the table entry layout, request and result codes, and the control
// group that the sequencer drives into the row of table cells.
// ----------------------------------------------------------------------------
package npta_pkg;

	// request codes carried by an input word
	typedef enum logic [1:0] {
		REQ_JOIN      = 2'd0,
		REQ_HEARTBEAT = 2'd1,
		REQ_TICK      = 2'd2,
		REQ_LOOKUP    = 2'd3
	} req_t;

	// result codes carried by an output word
	typedef enum logic [2:0] {
		KIND_NEW       = 3'd0,
		KIND_UPDATED   = 3'd1,
		KIND_REFRESHED = 3'd2,
		KIND_UNKNOWN   = 3'd3,
		KIND_OFFLINE   = 3'd4,
		KIND_FORWARD   = 3'd5,
		KIND_NOMATCH   = 3'd6,
		KIND_FULL_DONE = 3'd7
	} kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_FINAL,
		ST_FLUSH
	} state_t;

	localparam logic [7:0] RELOAD_RESET = 8'd3;

	// one table entry as it travels along the row
	typedef struct packed {
		logic        valid;
		logic [7:0]  tag;
		logic [15:0] addr;
		logic [7:0]  life;
	} entry_t;

	// sequencer to row: shift strobe and the entry fed back into the tail
	typedef struct packed {
		logic   shift;
		entry_t fb;
	} ring_ctl_t;

	// one result word
	typedef struct packed {
		kind_t       kind;
		logic [15:0] addr;
		logic [7:0]  tag;
	} result_t;

endpackage

// ===== hdl/npta_cell.sv =====
// ----------------------------------------------------------------------------
// npta_cell: one table slot in the rotating row
// Holds one entry and takes the entry of its neighbor whenever the row shifts.
// ----------------------------------------------------------------------------
module npta_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  npta_pkg::entry_t entry_in,
	output npta_pkg::entry_t entry_out
);

	logic        valid_q;
	logic [7:0]  tag_q;
	logic [15:0] addr_q;
	logic [7:0]  life_q;

	// valid flag, cleared on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= entry_in.valid;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (shift) begin
			tag_q  <= entry_in.tag;
			addr_q <= entry_in.addr;
			life_q <= entry_in.life;
		end
	end

	assign entry_out.valid = valid_q;
	assign entry_out.tag   = tag_q;
	assign entry_out.addr  = addr_q;
	assign entry_out.life  = life_q;

endmodule

// ===== hdl/npta_ctrl.sv =====
// ----------------------------------------------------------------------------
// npta_ctrl: request sequencer and head-of-row processing
// Rotates the row once per pass, inspects and edits the head entry, and
// emits result words through a one-deep pending register so that the last
// word of a run can be marked.
// ----------------------------------------------------------------------------
module npta_ctrl #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          req_type,
	input  logic [15:0]         node_addr,
	input  logic [7:0]          node_tag,
	input  logic                cfg_wr_en,
	input  logic [7:0]          cfg_wr_data,
	input  npta_pkg::entry_t    head,
	output npta_pkg::ring_ctl_t ring_ctl,
	output logic                result_strobe,
	output logic [2:0]          result_kind,
	output logic [15:0]         out_addr,
	output logic [7:0]          out_tag,
	output logic                last_of_run
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	npta_pkg::state_t  state_q, state_d;
	logic [IDX_W-1:0]  cnt_q, cnt_d;
	npta_pkg::req_t    req_q;
	logic [15:0]       addr_q;
	logic [7:0]        tag_q;
	logic [7:0]        reload_q;

	// search results of the first pass
	logic              hit_q, hit_d;
	logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
	logic [15:0]       hit_addr_q, hit_addr_d;
	logic [7:0]        hit_tag_q, hit_tag_d;
	logic              free_q, free_d;
	logic [IDX_W-1:0]  free_idx_q, free_idx_d;

	// pending word and output registers
	logic              pend_valid_q, pend_valid_d;
	npta_pkg::result_t pend_q, pend_d;
	logic              strobe_q, strobe_d;
	logic              last_q, last_d;
	npta_pkg::result_t res_q, res_d;

	logic              accept;
	logic              push;
	npta_pkg::result_t push_res;
	logic              flush;

	assign accept = start && (state_q == npta_pkg::ST_IDLE);
	assign busy   = (state_q != npta_pkg::ST_IDLE);

	// next state, head edits and result pushes
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		hit_d         = hit_q;
		hit_idx_d     = hit_idx_q;
		hit_addr_d    = hit_addr_q;
		hit_tag_d     = hit_tag_q;
		free_d        = free_q;
		free_idx_d    = free_idx_q;
		ring_ctl.shift = 1'b0;
		ring_ctl.fb    = head;
		push          = 1'b0;
		push_res      = '{kind: npta_pkg::KIND_NEW, addr: 16'd0, tag: 8'd0};
		flush         = 1'b0;
		case (state_q)
			npta_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = npta_pkg::ST_SCAN;
					cnt_d   = '0;
					hit_d   = 1'b0;
					free_d  = 1'b0;
				end
			end
			npta_pkg::ST_SCAN: begin
				ring_ctl.shift = 1'b1;
				case (req_q)
					npta_pkg::REQ_JOIN: begin
						if (head.valid && head.tag == tag_q && !hit_q) begin
							hit_d     = 1'b1;
							hit_idx_d = cnt_q;
						end
						if (!head.valid && !free_q) begin
							free_d     = 1'b1;
							free_idx_d = cnt_q;
						end
					end
					npta_pkg::REQ_HEARTBEAT: begin
						if (head.valid && head.addr == addr_q) begin
							ring_ctl.fb.life = reload_q;
							push = 1'b1;
							push_res = '{kind: npta_pkg::KIND_REFRESHED,
								addr: head.addr, tag: head.tag};
						end
					end
					npta_pkg::REQ_TICK: begin
						if (head.valid) begin
							if (head.life <= 8'd1) begin
								ring_ctl.fb.valid = 1'b0;
								ring_ctl.fb.life  = 8'd0;
								push = 1'b1;
								push_res = '{kind: npta_pkg::KIND_OFFLINE,
									addr: head.addr, tag: head.tag};
							end else begin
								ring_ctl.fb.life = head.life - 8'd1;
							end
						end
					end
					npta_pkg::REQ_LOOKUP: begin
						if (head.valid && head.tag == tag_q && !hit_q) begin
							hit_d      = 1'b1;
							hit_addr_d = head.addr;
							hit_tag_d  = head.tag;
						end
					end
					default: begin
					end
				endcase
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = (req_q == npta_pkg::REQ_JOIN) ? npta_pkg::ST_APPLY
						: npta_pkg::ST_FINAL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			npta_pkg::ST_APPLY: begin
				// second join pass writes the chosen slot
				ring_ctl.shift = 1'b1;
				if (hit_q && cnt_q == hit_idx_q) begin
					ring_ctl.fb.addr = addr_q;
					ring_ctl.fb.life = reload_q;
				end else if (!hit_q && free_q && cnt_q == free_idx_q) begin
					ring_ctl.fb = '{valid: 1'b1, tag: tag_q, addr: addr_q, life: reload_q};
				end
				if (cnt_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = npta_pkg::ST_FINAL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			npta_pkg::ST_FINAL: begin
				state_d = npta_pkg::ST_FLUSH;
				case (req_q)
					npta_pkg::REQ_JOIN: begin
						push = 1'b1;
						if (hit_q) begin
							push_res = '{kind: npta_pkg::KIND_UPDATED, addr: addr_q, tag: tag_q};
						end else if (free_q) begin
							push_res = '{kind: npta_pkg::KIND_NEW, addr: addr_q, tag: tag_q};
						end else begin
							push_res = '{kind: npta_pkg::KIND_FULL_DONE, addr: addr_q,
								tag: tag_q};
						end
					end
					npta_pkg::REQ_HEARTBEAT: begin
						if (!pend_valid_q) begin
							push = 1'b1;
							push_res = '{kind: npta_pkg::KIND_UNKNOWN, addr: addr_q, tag: 8'd0};
						end
					end
					npta_pkg::REQ_TICK: begin
						push = 1'b1;
						push_res = '{kind: npta_pkg::KIND_FULL_DONE, addr: 16'd0, tag: 8'd0};
					end
					npta_pkg::REQ_LOOKUP: begin
						push = 1'b1;
						if (hit_q) begin
							push_res = '{kind: npta_pkg::KIND_FORWARD, addr: hit_addr_q,
								tag: hit_tag_q};
						end else begin
							push_res = '{kind: npta_pkg::KIND_NOMATCH, addr: 16'd0, tag: tag_q};
						end
					end
					default: begin
					end
				endcase
			end
			npta_pkg::ST_FLUSH: begin
				flush   = 1'b1;
				state_d = npta_pkg::ST_IDLE;
			end
			default: begin
				state_d = npta_pkg::ST_IDLE;
			end
		endcase
	end

	// pending word: a push sends out the previous word, flush sends the last
	always_comb begin
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		strobe_d     = 1'b0;
		last_d       = 1'b0;
		res_d        = res_q;
		if (accept) begin
			pend_valid_d = 1'b0;
		end else if (push) begin
			pend_valid_d = 1'b1;
			pend_d       = push_res;
			if (pend_valid_q) begin
				strobe_d = 1'b1;
				res_d    = pend_q;
			end
		end else if (flush) begin
			pend_valid_d = 1'b0;
			strobe_d     = pend_valid_q;
			last_d       = 1'b1;
			res_d        = pend_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= npta_pkg::ST_IDLE;
			cnt_q        <= '0;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
			reload_q     <= npta_pkg::RELOAD_RESET;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			hit_q        <= hit_d;
			free_q       <= free_d;
			pend_valid_q <= pend_valid_d;
			strobe_q     <= strobe_d;
			if (cfg_wr_en) begin
				reload_q <= cfg_wr_data;
			end
		end
	end

	// request word and payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= npta_pkg::req_t'(req_type);
			addr_q <= node_addr;
			tag_q  <= node_tag;
		end
		hit_idx_q  <= hit_idx_d;
		hit_addr_q <= hit_addr_d;
		hit_tag_q  <= hit_tag_d;
		free_idx_q <= free_idx_d;
		pend_q     <= pend_d;
		res_q      <= res_d;
		last_q     <= last_d;
	end

	assign result_strobe = strobe_q;
	assign result_kind   = res_q.kind;
	assign out_addr      = res_q.addr;
	assign out_tag       = res_q.tag;
	assign last_of_run   = last_q;

endmodule

// ===== hdl/node_presence_table_aging_unit.sv =====
// A join makes two passes of the row before its last word, other requests one;
// a tick emits up to TABLE_DEPTH+1 words, one per cycle.
// Throughput: one request at a time, set by the full rotation of the slot row
// past the single head processing point (two rotations for a join).
// Results appear one cycle each on result_strobe; the receiver cannot stall.
// Reset empties the table at once (valid flags cleared) and loads reload 3.
// ----------------------------------------------------------------------------
// node_presence_table_aging_unit: keepalive node table with aging
// A row of slot cells rotates past a sequencer that joins, refreshes, ages
// and looks up node entries.
// ----------------------------------------------------------------------------
module node_presence_table_aging_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] node_addr,
	input  logic [7:0]  node_tag,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,
	output logic        result_strobe,
	output logic [2:0]  result_kind,
	output logic [15:0] out_addr,
	output logic [7:0]  out_tag,
	output logic        last_of_run
);

	npta_pkg::entry_t    row [TABLE_DEPTH];
	npta_pkg::ring_ctl_t ring_ctl;

	// row of slot cells, head at cell 0, sequencer feeds the tail
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		npta_pkg::entry_t nxt;
		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign nxt = ring_ctl.fb;
		end else begin : g_body
			assign nxt = row[i+1];
		end
		npta_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (ring_ctl.shift),
			.entry_in  (nxt),
			.entry_out (row[i])
		);
	end

	// sequencer
	npta_ctrl #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.node_addr     (node_addr),
		.node_tag      (node_tag),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.head          (row[0]),
		.ring_ctl      (ring_ctl),
		.result_strobe (result_strobe),
		.result_kind   (result_kind),
		.out_addr      (out_addr),
		.out_tag       (out_tag),
		.last_of_run   (last_of_run)
	);

endmodule

// ===== hdl/npta_checker.sv =====
// ----------------------------------------------------------------------------
// npta_checker: port-level checks of the node presence table
// Watches the command handshake and the result word framing over time.
// ----------------------------------------------------------------------------
module npta_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       result_strobe,
	input logic       last_of_run
);

	// an accepted request keeps the unit busy in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accept");

	// no word appears right after an accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_strobe)
		else $error("result word right after accept");

	// the closing word of a run comes once the unit is free again
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_of_run) |-> !busy)
		else $error("last word while busy");

	// intermediate words only while the run goes on
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_of_run) |-> busy)
		else $error("intermediate word while idle");

	// every run ends with a marked last word
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_strobe && last_of_run))
		else $error("run ended without last word");

endmodule

bind node_presence_table_aging_unit npta_checker u_npta_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.last_of_run   (last_of_run)
);
